### src/dabs_pkg.sv
// Shared types and constants for the deformable attention bilinear sampler.
// No dependencies.
package dabs_pkg;

	localparam int MaxLevels = 8;
	localparam int LvlW = $clog2(MaxLevels);

	// Configuration register indexes.
	localparam logic [2:0] RegHeads   = 3'd0;
	localparam logic [2:0] RegQueries = 3'd1;
	localparam logic [2:0] RegKeys    = 3'd2;
	localparam logic [2:0] RegLevels  = 3'd3;
	localparam logic [2:0] RegPoints  = 3'd4;

	// Operation codes for the shared arithmetic unit.
	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
		logic [31:0] rem;
	} alu_rsp_t;

endpackage

### src/deformable_attention_bilinear_sampler_core.sv
// Top level of the deformable attention bilinear sampler: sequencer, level
// start table and corner output. Depends on dabs_pkg and dabs_alu.
//
//  channel | signals                          | direction
//  cfg     | cfg_valid cfg_ready cfg_index .. | in (write)
//  in      | in_valid in_stall + fields       | in
//  out     | out_valid out_stall + fields     | out
//
// Each item runs fourteen passes of the shared multiply/divide unit (two
// divides, twelve multiplies) and four weight steps, and hands out one word
// per corner.
// Reset clears the point counter, start table, cache flag, valid bits and the
// sequencer. in_stall is high while an item is at work; out_stall holds the
// current word.
module deformable_attention_bilinear_sampler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] unit_index,
	input  logic [14:0] level_width,
	input  logic [14:0] level_height,
	input  logic signed [15:0] x_floor,
	input  logic signed [15:0] y_floor,
	input  logic [15:0] frac_x,
	input  logic [15:0] frac_y,
	input  logic [15:0] attn_weight,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  corner,
	output logic        in_bounds,
	output logic [31:0] row_index,
	output logic [16:0] corner_weight,
	output logic [15:0] weight_out,
	output logic        last
);
	import dabs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_HQ, S_BATCH, S_HEAD, S_BK, S_BKH, S_LSH,
		S_YW, S_KH, S_WT, S_OUT
	} state_t;

	state_t      state_q;
	logic [6:0]  heads_q;
	logic [15:0] queries_q;
	logic [23:0] keys_q;
	logic [3:0]  levels_q;
	logic [5:0]  points_q;

	logic [7:0]  pcnt_q;
	logic [31:0] lst_q [MaxLevels];
	logic [31:0] parea_q;
	logic        cached_q;

	logic [23:0] unit_q;
	logic [14:0] w_q;
	logic [14:0] h_q;
	logic signed [15:0] xl_q;
	logic signed [15:0] yl_q;
	logic [15:0] fx_q;
	logic [15:0] fy_q;
	logic [15:0] aw_q;
	logic [LvlW-1:0] lvl_q;
	logic [31:0] batch_q;
	logic [31:0] base_q;
	logic [31:0] key_q;
	logic [1:0]  cor_q;
	logic [1:0]  wsel_q;
	logic [16:0] wts_q [4];

	// Operands for the shared unit and its one-cycle launch pulse.
	logic        astart_q;
	alu_op_t     aop_q;
	logic [31:0] aopa_q;
	logic [31:0] aopb_q;
	logic        launch_c;

	alu_req_t req;
	alu_rsp_t rsp;

	assign req = '{start: astart_q, op: aop_q, a: aopa_q, b: aopb_q};

	dabs_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// Effective register values after saturation.
	logic [6:0]  h_eff;
	logic [15:0] q_eff;
	logic [3:0]  l_eff;
	logic [5:0]  p_eff;
	logic [8:0]  total;
	always_comb begin
		h_eff = (heads_q == 7'd0) ? 7'd1 : heads_q;
		q_eff = (queries_q == 16'd0) ? 16'd1 : queries_q;
		l_eff = (levels_q == 4'd0) ? 4'd1 :
			(levels_q > 4'(MaxLevels)) ? 4'(MaxLevels) : levels_q;
		p_eff = (points_q == 6'd0) ? 6'd1 : (points_q > 6'd32) ? 6'd32 : points_q;
		total = 9'(l_eff) * 9'(p_eff);
	end

	// Level and first-point test by repeated subtraction of P.
	logic [7:0]       pc_eff;
	logic [LvlW-1:0]  lvl_c;
	logic             first_c;
	logic [8:0]       rest;
	always_comb begin
		pc_eff = (9'(pcnt_q) >= total) ? 8'd0 : pcnt_q;
		rest = 9'(pc_eff);
		lvl_c = '0;
		for (int i = 0; i < MaxLevels - 1; i++) begin
			if (rest >= 9'(p_eff)) begin
				rest = rest - 9'(p_eff);
				lvl_c = lvl_c + 1'b1;
			end
		end
		first_c = (rest == 9'd0);
	end

	// Corner geometry.
	logic signed [16:0] cx;
	logic signed [16:0] cy;
	logic        ok;
	always_comb begin
		cx = 17'(xl_q) + (cor_q[1] ? 17'sd1 : 17'sd0);
		cy = 17'(yl_q) + (cor_q[0] ? 17'sd1 : 17'sd0);
		ok = !cx[16] && !cy[16] && (cx < $signed({2'b0, w_q})) &&
			(cy < $signed({2'b0, h_q}));
	end

	// Weight factors for the four corners.
	logic [16:0] wa;
	logic [16:0] wb;
	always_comb begin
		wa = wsel_q[1] ? {1'b0, fx_q} : 17'h10000 - {1'b0, fx_q};
		wb = wsel_q[0] ? {1'b0, fy_q} : 17'h10000 - {1'b0, fy_q};
	end

	logic [33:0] wprod;
	assign wprod = 34'(wa) * 34'(wb) + 34'd32768;

	// States that hand a new operation to the shared unit; the launch is registered into astart_q.
	always_comb begin
		case (state_q)
			S_PREP: launch_c = 1'b1;
			S_HQ, S_BATCH, S_HEAD, S_BK, S_BKH, S_LSH, S_YW: launch_c = rsp.done;
			S_OUT: launch_c = !out_stall && (cor_q != 2'd3);
			default: launch_c = 1'b0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heads_q <= 7'd8;
			queries_q <= 16'd1;
			keys_q <= 24'd1;
			levels_q <= 4'd4;
			points_q <= 6'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegHeads:   heads_q <= cfg_data[6:0];
				RegQueries: queries_q <= cfg_data[15:0];
				RegKeys:    keys_q <= cfg_data;
				RegLevels:  levels_q <= cfg_data[3:0];
				RegPoints:  points_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Sequencer: each arithmetic step launches the shared unit and waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pcnt_q <= '0;
			parea_q <= '0;
			cached_q <= 1'b0;
			out_valid <= 1'b0;
			astart_q <= 1'b0;
			for (int i = 0; i < MaxLevels; i++) lst_q[i] <= '0;
		end else begin
			astart_q <= launch_c;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unit_q <= unit_index;
						w_q <= level_width;
						h_q <= level_height;
						xl_q <= x_floor;
						yl_q <= y_floor;
						fx_q <= frac_x;
						fy_q <= frac_y;
						aw_q <= attn_weight;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					lvl_q <= lvl_c;
					if (first_c) begin
						if (!cached_q && lvl_c != '0)
							lst_q[lvl_c] <= lst_q[lvl_c - 1'b1] + parea_q;
						parea_q <= 32'(w_q) * 32'(h_q);
					end
					if (9'(pc_eff) + 9'd1 >= total) begin
						pcnt_q <= '0;
						cached_q <= 1'b1;
					end else begin
						pcnt_q <= pc_eff + 8'd1;
					end
					aop_q <= OP_MUL;
					aopa_q <= 32'(h_eff);
					aopb_q <= 32'(q_eff);
					state_q <= S_HQ;
				end
				S_HQ: if (rsp.done) begin
					aop_q <= OP_DIV;
					aopa_q <= 32'(unit_q);
					aopb_q <= rsp.res;
					state_q <= S_BATCH;
				end
				S_BATCH: if (rsp.done) begin
					batch_q <= rsp.res;
					aop_q <= OP_DIV;
					aopa_q <= 32'(unit_q);
					aopb_q <= 32'(h_eff);
					state_q <= S_HEAD;
				end
				S_HEAD: if (rsp.done) begin
					base_q <= rsp.rem;
					aop_q <= OP_MUL;
					aopa_q <= batch_q;
					aopb_q <= 32'(keys_q);
					state_q <= S_BK;
				end
				S_BK: if (rsp.done) begin
					aop_q <= OP_MUL;
					aopa_q <= rsp.res;
					aopb_q <= 32'(h_eff);
					state_q <= S_BKH;
				end
				S_BKH: if (rsp.done) begin
					base_q <= base_q + rsp.res;
					aop_q <= OP_MUL;
					aopa_q <= lst_q[lvl_q];
					aopb_q <= 32'(h_eff);
					state_q <= S_LSH;
				end
				S_LSH: if (rsp.done) begin
					base_q <= base_q + rsp.res;
					cor_q <= 2'd0;
					aop_q <= OP_MUL;
					aopa_q <= 32'(yl_q);
					aopb_q <= 32'(w_q);
					state_q <= S_YW;
				end
				// Row key for the current corner.
				S_YW: if (rsp.done) begin
					key_q <= rsp.res + 32'(cx);
					aop_q <= OP_MUL;
					aopa_q <= rsp.res + 32'(cx);
					aopb_q <= 32'(h_eff);
					state_q <= S_KH;
				end
				S_KH: if (rsp.done) begin
					key_q <= base_q + rsp.res;
					wsel_q <= 2'd0;
					state_q <= (cor_q == 2'd0) ? S_WT : S_OUT;
					out_valid <= (cor_q != 2'd0);
				end
				// Four corner weights, one multiply each.
				S_WT: begin
					wts_q[wsel_q] <= wprod[32:16];
					wsel_q <= wsel_q + 2'd1;
					if (wsel_q == 2'd3) begin
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					if (cor_q == 2'd3) begin
						state_q <= S_IDLE;
					end else begin
						cor_q <= cor_q + 2'd1;
						aop_q <= OP_MUL;
						aopa_q <= 32'(yl_q) + (cor_q[0] ? 32'd0 : 32'd1);
						aopb_q <= 32'(w_q);
						state_q <= S_YW;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output word from the current corner.
	assign corner = cor_q;
	assign in_bounds = ok;
	assign row_index = ok ? key_q : 32'd0;
	assign corner_weight = ok ? wts_q[cor_q] : 17'd0;
	assign weight_out = aw_q;
	assign last = (cor_q == 2'd3);

`ifndef NO_ASSERTIONS
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("output word while idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cor_q))
		else $error("stalled word dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (9'(pcnt_q) < total || cached_q || pcnt_q == 8'd0))
		else $error("point counter out of range");
`endif

endmodule

### src/dabs_alu.sv
// Shared multi-cycle arithmetic unit: 32x32 multiply (low 32 bits) done one
// bit per cycle, and 32-bit unsigned divide, one quotient bit per cycle.
// Depends on dabs_pkg.
module dabs_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  dabs_pkg::alu_req_t req,
	output dabs_pkg::alu_rsp_t rsp
);
	import dabs_pkg::*;

	logic        busy_q;
	logic        done_q;
	alu_op_t     op_q;
	logic [5:0]  cnt_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] acc_q;
	logic [31:0] rem_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	assign rem_sh = {rem_q[30:0], a_q[31]};
	assign trial = {1'b0, rem_sh} - {1'b0, b_q};

	// One step of shift-add or restoring division per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 6'd31);
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= '0;
				a_q <= req.a;
				b_q <= req.b;
				acc_q <= '0;
				rem_q <= '0;
			end else if (busy_q) begin
				case (op_q)
					OP_MUL: begin
						if (a_q[0]) acc_q <= acc_q + b_q;
						a_q <= {1'b0, a_q[31:1]};
						b_q <= {b_q[30:0], 1'b0};
					end
					OP_DIV: begin
						a_q <= {a_q[30:0], 1'b0};
						if (!trial[32]) begin
							rem_q <= trial[31:0];
							acc_q <= {acc_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							acc_q <= {acc_q[30:0], 1'b0};
						end
					end
					default: ;
				endcase
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp = '{done: done_q, res: acc_q, rem: rem_q};

endmodule

### test/tb_top.sv
// Self-checking testbench for the deformable attention bilinear sampler core.
// Depends on dabs_pkg and the core RTL; a scoreboard class predicts four corner words per point.
module tb_top;
	import dabs_pkg::*;

	typedef struct {
		bit [23:0] unit;
		bit [14:0] w;
		bit [14:0] ht;
		bit [15:0] xf;
		bit [15:0] yf;
		bit [15:0] fx;
		bit [15:0] fy;
		bit [15:0] aw;
	} point_t;

	typedef struct {
		bit [1:0]  corner;
		bit        inb;
		bit [31:0] row;
		bit [16:0] wt;
		bit [15:0] aw;
		bit        last;
	} corner_word_t;

	// Corner predictor with its own copy of the registers and the sequencing state.
	class corner_scoreboard;
		bit [6:0]  heads = 8;
		bit [15:0] queries = 1;
		bit [23:0] keys = 1;
		bit [3:0]  levels = 4;
		bit [5:0]  points = 4;
		bit [31:0] pt_cnt = 0;
		bit [31:0] start_tbl [MaxLevels];
		bit [31:0] prev_area = 0;
		bit        cached = 0;
		corner_word_t pending_q [$];
		int errors = 0;
		int words = 0;

		function new();
			foreach (start_tbl[i]) start_tbl[i] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, bit [23:0] val);
			case (idx)
				RegHeads:   heads = val[6:0];
				RegQueries: queries = val[15:0];
				RegKeys:    keys = val[23:0];
				RegLevels:  levels = val[3:0];
				RegPoints:  points = val[5:0];
				default: ;
			endcase
		endfunction

		// Note an accepted point and queue its four expected corner words.
		function void note_point(point_t p);
			bit [31:0] h, q, lv, pt, total, lvl, batch, head, base, key;
			longint unsigned wts [4];
			longint unsigned ifx, ify;
			int x, y, w, ht;
			corner_word_t cw;
			h = heads ? heads : 1;
			q = queries ? queries : 1;
			lv = levels < 1 ? 1 : (levels > MaxLevels ? MaxLevels : levels);
			pt = points < 1 ? 1 : (points > 32 ? 32 : points);
			total = lv * pt;
			w = p.w;
			ht = p.ht;
			if (pt_cnt >= total) pt_cnt = 0;
			lvl = pt_cnt / pt;
			// The first point of a level extends the start table until it is cached.
			if (pt_cnt % pt == 0) begin
				if (!cached && lvl > 0) start_tbl[lvl] = start_tbl[lvl-1] + prev_area;
				prev_area = p.w * p.ht;
			end
			batch = p.unit / (h * q);
			head = p.unit % h;
			base = batch * keys * h + start_tbl[lvl] * h + head;
			ifx = 65536 - p.fx;
			ify = 65536 - p.fy;
			wts[0] = (ifx * ify + 32768) >> 16;
			wts[1] = (ifx * p.fy + 32768) >> 16;
			wts[2] = (p.fx * ify + 32768) >> 16;
			wts[3] = (p.fx * p.fy + 32768) >> 16;
			for (int c = 0; c < 4; c++) begin
				x = $signed(p.xf) + ((c & 2) ? 1 : 0);
				y = $signed(p.yf) + ((c & 1) ? 1 : 0);
				cw.corner = 2'(c);
				cw.inb = x >= 0 && y >= 0 && x <= w - 1 && y <= ht - 1;
				key = y * w + x;
				cw.row = cw.inb ? base + key * h : 32'd0;
				cw.wt = cw.inb ? wts[c][16:0] : 17'd0;
				cw.aw = p.aw;
				cw.last = (c == 3);
				pending_q.push_back(cw);
			end
			pt_cnt++;
			if (pt_cnt >= total) begin
				pt_cnt = 0;
				cached = 1;
			end
		endfunction

		// Compare one accepted corner word with the oldest expectation.
		function void check_word(corner_word_t a);
			corner_word_t e;
			words++;
			if (pending_q.size() == 0) begin
				$error("unexpected corner word, corner %0d", a.corner);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (a.corner !== e.corner) begin
				$error("corner: expected %0d, got %0d", e.corner, a.corner); errors++;
			end
			if (a.inb !== e.inb) begin
				$error("in_bounds: expected %0d, got %0d", e.inb, a.inb); errors++;
			end
			if (a.row !== e.row) begin
				$error("row_index: expected %0d, got %0d", e.row, a.row); errors++;
			end
			if (a.wt !== e.wt) begin
				$error("corner_weight: expected %0d, got %0d", e.wt, a.wt); errors++;
			end
			if (a.aw !== e.aw) begin
				$error("weight_out: expected %0d, got %0d", e.aw, a.aw); errors++;
			end
			if (a.last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, a.last); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid, in_stall;
	logic [23:0] unit_index;
	logic [14:0] level_width, level_height;
	logic signed [15:0] x_floor, y_floor;
	logic [15:0] frac_x, frac_y, attn_weight;
	logic out_valid, out_stall;
	logic [1:0] corner;
	logic in_bounds, last;
	logic [31:0] row_index;
	logic [16:0] corner_weight;
	logic [15:0] weight_out;

	corner_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;
	int sent = 0;
	bit [14:0] lvl_w [MaxLevels];
	bit [14:0] lvl_h [MaxLevels];

	deformable_attention_bilinear_sampler_core u_dut (.*);

	always #1 clk = ~clk;

	initial begin
		cfg_valid <= 0; cfg_index <= 0; cfg_data <= 0;
		in_valid <= 0; unit_index <= 0; level_width <= 1; level_height <= 1;
		x_floor <= 0; y_floor <= 0; frac_x <= 0; frac_y <= 0; attn_weight <= 0;
		out_stall <= 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// Result monitor.
	always @(posedge clk) begin
		corner_word_t a;
		if (arst_n && out_valid && !out_stall) begin
			a.corner = corner; a.inb = in_bounds; a.row = row_index;
			a.wt = corner_weight; a.aw = weight_out; a.last = last;
			sb.check_word(a);
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1;
				repeat (3000) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_stall <= 0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Withdraw the input and wait until every expected word has come.
	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, bit [23:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_regs(bit [23:0] h, bit [23:0] q, bit [23:0] k, bit [23:0] l, bit [23:0] p);
		wait_drained();
		write_reg(RegHeads, h);
		write_reg(RegQueries, q);
		write_reg(RegKeys, k);
		write_reg(RegLevels, l);
		write_reg(RegPoints, p);
	endtask

	// Offer one point and hold it until the core takes it.
	task automatic send_point(point_t p);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1;
		unit_index <= p.unit; level_width <= p.w; level_height <= p.ht;
		x_floor <= p.xf; y_floor <= p.yf; frac_x <= p.fx; frac_y <= p.fy;
		attn_weight <= p.aw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_point(p);
		sent++;
	endtask

	function automatic point_t noise_point();
		point_t p;
		p.unit = 24'($urandom); p.w = 15'($urandom); p.ht = 15'($urandom);
		p.xf = 16'($urandom); p.yf = 16'($urandom); p.fx = 16'($urandom);
		p.fy = 16'($urandom);
		p.aw = 16'($urandom);
		return p;
	endfunction

	// Runs whole units: level sizes stay fixed per level apart from random noise points, coordinates hug the map.
	task automatic run_units(int n_items, int l_n, int p_n, bit [23:0] unit_hi);
		point_t p;
		int w, ht, lvl;
		int pos = 0;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 6) == 0) begin
				p = noise_point();
			end else begin
				lvl = pos / p_n;
				w = lvl_w[lvl]; ht = lvl_h[lvl];
				p.unit = 24'($urandom_range(0, unit_hi));
				p.w = 15'(w); p.ht = 15'(ht);
				p.xf = 16'((w > 200) ? $urandom_range(0, w + 1) - 1 :
					$urandom_range(0, w + 3) - 2);
				p.yf = 16'((ht > 200) ? $urandom_range(0, ht + 1) - 1 :
					$urandom_range(0, ht + 3) - 2);
				p.fx = 16'($urandom); p.fy = 16'($urandom); p.aw = 16'($urandom);
			end
			send_point(p);
			pos = (pos + 1) % (l_n * p_n);
		end
	endtask

	task automatic new_sizes(bit big);
		foreach (lvl_w[i]) begin
			lvl_w[i] = 15'($urandom_range(1, 40));
			lvl_h[i] = 15'($urandom_range(1, 40));
		end
		if (big) begin
			lvl_w[0] = 15'h7fff;
			lvl_h[1] = 15'h7fff;
		end
	endtask

	initial begin
		point_t p;
		@(posedge arst_n);
		@(posedge clk);

		// First unit covers every level so the whole start table gets built.
		new_sizes(0);
		set_regs(8, 1, 1, 8, 1);
		run_units(0, 8, 1, 0);
		for (int i = 0; i < 8; i++) begin
			p = noise_point();
			p.w = lvl_w[i]; p.ht = lvl_h[i]; p.xf = 0; p.yf = 0;
			send_point(p);
		end

		// Directed points: field extremes and the map edges.
		set_regs(4, 2, 1000, 2, 2);
		p = '{24'hffffff, 15'h7fff, 15'h7fff, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0};
		send_point(p);
		p = '{24'h0, 15'h7fff, 15'h7fff, 16'h7ffe, 16'h7ffe, 16'hffff, 16'hffff, 16'hffff};
		send_point(p);
		p = '{24'h5, 15'd1, 15'd1, 16'h0, 16'h0, 16'h8000, 16'h8000, 16'h1234};
		send_point(p);
		p = '{24'h6, 15'd1, 15'd1, 16'hffff, 16'hffff, 16'h0001, 16'hffff, 16'h8000};
		send_point(p);
		p = '{24'h7, 15'd10, 15'd20, 16'd9, 16'd19, 16'h4000, 16'h0, 16'h00ff};
		send_point(p);
		p = '{24'h9, 15'd10, 15'd20, 16'h7fff, 16'd0, 16'h0, 16'hc000, 16'hff00};
		send_point(p);
		p = '{24'h3, 15'd3, 15'd3, 16'hffff, 16'd2, 16'hffff, 16'h0, 16'h5555};
		send_point(p);
		p = '{24'h8, 15'd3, 15'd3, 16'd1, 16'hffff, 16'h0, 16'hffff, 16'haaaa};
		send_point(p);

		// Smallest settings.
		new_sizes(0);
		set_regs(1, 1, 1, 1, 1);
		run_units(40, 1, 1, 50);

		// Register zero values; long hold-off on the receiver.
		new_sizes(0);
		set_regs(0, 0, 0, 0, 0);
		hold_req = 1;
		run_units(50, 1, 1, 1000);

		// Above-range values saturate.
		new_sizes(1);
		set_regs(127, 3, 100, 15, 63);
		run_units(40, 8, 32, 24'hffffff);

		// Largest legal settings, few points.
		new_sizes(1);
		set_regs(64, 65535, 24'hffffff, 8, 32);
		run_units(30, 8, 32, 24'hffffff);

		// Typical settings; sender pauses until everything has drained.
		new_sizes(0);
		set_regs(3, 2, 500, 3, 2);
		run_units(60, 3, 2, 200);
		wait_drained();
		run_units(40, 3, 2, 200);

		// Random settings.
		for (int r = 0; r < 3; r++) begin
			new_sizes(r == 1);
			set_regs(24'($urandom_range(1, 64)), 24'($urandom_range(1, 65535)),
				24'($urandom), 24'($urandom_range(1, 8)), 24'($urandom_range(1, 4)));
			run_units(40, sb.levels, sb.points, 24'($urandom));
		end

		// Last stretch runs without idling.
		quiet = 1;
		new_sizes(0);
		set_regs(2, 4, 77, 4, 3);
		run_units(60, 4, 3, 100);
		in_valid <= 0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Sent %0d points over eleven register settings, with field extremes,",
			sent);
		$display("saturated registers, a long receiver hold-off and a full drain; %0d words.",
			sb.words);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule
